@@ sv/todc_pkg.sv @@
package todc_pkg;

    localparam int HourW = 5;
    localparam int UnitW = 6;
    localparam int HhmmW = 12;

    localparam logic [UnitW-1:0] HOUR_TOP   = 6'd23;
    localparam logic [UnitW-1:0] MINUTE_TOP = 6'd59;
    localparam logic [6:0]       UNIT_MOD   = 7'd60;
    localparam logic [HhmmW-1:0] HOUR_SCALE = 12'd100;

    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_CLK_HOUR   = 4'd1,
        CMD_CLK_MINUTE = 4'd2,
        CMD_ALM_HOUR   = 4'd3,
        CMD_ALM_MINUTE = 4'd4,
        CMD_SET_CLOCK  = 4'd5,
        CMD_SET_ALARM  = 4'd6,
        CMD_SNOOZE     = 4'd7,
        CMD_ARM        = 4'd8
    } cmd_t;

    typedef struct packed {
        logic [3:0]       cmd;
        logic signed [1:0] step;
        logic [HourW-1:0] hour_value;
        logic [UnitW-1:0] minute_value;
        logic [UnitW-1:0] snooze_minutes;
        logic [UnitW-1:0] snooze_seconds;
        logic             arm_flag;
    } req_t;

    typedef struct packed {
        logic [HourW-1:0] clk_hours;
        logic [UnitW-1:0] clk_minutes;
        logic [UnitW-1:0] clk_seconds;
        logic [HourW-1:0] alm_hours;
        logic [UnitW-1:0] alm_minutes;
        logic [HourW-1:0] nxt_hours;
        logic [UnitW-1:0] nxt_minutes;
        logic [UnitW-1:0] nxt_seconds;
        logic             armed;
    } state_t;

    typedef struct packed {
        logic [HhmmW-1:0] clock_hhmm;
        logic [HhmmW-1:0] alarm_hhmm;
        logic             second_odd;
        logic             alarm_due;
    } result_t;

    function automatic logic [UnitW-1:0] clamp_unit(input logic [UnitW-1:0] v,
                                                   input logic [UnitW-1:0] top);
        return (v > top) ? top : v;
    endfunction

    // +1 / -1 / hold with wrap; top is modulus minus one
    function automatic logic [UnitW-1:0] nudge(input logic [UnitW-1:0] v,
                                              input logic up,
                                              input logic dn,
                                              input logic [UnitW-1:0] top);
        logic [UnitW-1:0] r;
        r = v;
        if (up)
            r = (v >= top) ? '0 : v + 1'b1;
        else if (dn)
            r = (v == '0) ? top : v - 1'b1;
        return r;
    endfunction

    function automatic logic [HhmmW-1:0] to_hhmm(input logic [HourW-1:0] h,
                                                input logic [UnitW-1:0] m);
        return {{(HhmmW-HourW){1'b0}}, h} * HOUR_SCALE + {{(HhmmW-UnitW){1'b0}}, m};
    endfunction

endpackage

@@ sv/todc_req_if.sv @@
interface todc_req_if;
    import todc_pkg::*;

    logic              valid;
    logic              ready;
    logic [3:0]        cmd;
    logic signed [1:0] step;
    logic [HourW-1:0]  hour_value;
    logic [UnitW-1:0]  minute_value;
    logic [UnitW-1:0]  snooze_minutes;
    logic [UnitW-1:0]  snooze_seconds;
    logic              arm_flag;

    modport source (
        output valid, cmd, step, hour_value, minute_value,
               snooze_minutes, snooze_seconds, arm_flag,
        input  ready
    );

    modport sink (
        input  valid, cmd, step, hour_value, minute_value,
               snooze_minutes, snooze_seconds, arm_flag,
        output ready
    );
endinterface

@@ sv/todc_res_if.sv @@
interface todc_res_if;
    import todc_pkg::*;

    logic             valid;
    logic             ready;
    logic [HhmmW-1:0] clock_hhmm;
    logic [HhmmW-1:0] alarm_hhmm;
    logic             second_odd;
    logic             alarm_due;

    modport source (
        output valid, clock_hhmm, alarm_hhmm, second_odd, alarm_due,
        input  ready
    );

    modport sink (
        input  valid, clock_hhmm, alarm_hhmm, second_odd, alarm_due,
        output ready
    );
endinterface

@@ sv/time_of_day_clock_with_snooze_alarm.sv @@
// 24-hour time-of-day clock with a set alarm and a snooze-adjusted next-alarm
// time. Each request carries one command (tick, nudge clock/alarm hour or
// minute, set clock, set alarm, snooze, arm) and produces exactly one result
// showing the state after that command: clock and alarm as hour*100+minute,
// seconds parity and the alarm-due flag. Throughput is one request per clock;
// the request register loads at acceptance, and the state update and result
// register then load together in one pass when the request advances to the
// result stage. The result register is decoupled by its own valid, so a new
// request is taken while a finished result waits, and requests stall only
// when both stages are full and the result is not taken. Out-of-range hour,
// minute and snooze values saturate to their maximum; unused command codes
// leave the state unchanged.
module time_of_day_clock_with_snooze_alarm
    import todc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    todc_req_if.sink   req,
    todc_res_if.source result
);

    // request stage
    logic    req_valid_reg;
    req_t    req_data_reg;

    // result stage
    logic    res_valid_reg;
    result_t res_data_reg;

    // architectural state
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;

    logic    advance;

    // request stage moves to the result stage when the result slot is free or its result is being taken
    assign advance   = req_valid_reg && (!res_valid_reg || result.ready);
    assign req.ready = !req_valid_reg || advance;

    todc_update u_update (
        .req (req_data_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req.ready)
                req_valid_reg <= req.valid;
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;   // state commits with its result
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_data_reg.cmd            <= req.cmd;
            req_data_reg.step           <= req.step;
            req_data_reg.hour_value     <= req.hour_value;
            req_data_reg.minute_value   <= req.minute_value;
            req_data_reg.snooze_minutes <= req.snooze_minutes;
            req_data_reg.snooze_seconds <= req.snooze_seconds;
            req_data_reg.arm_flag       <= req.arm_flag;
        end
        if (advance)
            res_data_reg <= res_next;
    end

    assign result.valid      = res_valid_reg;
    assign result.clock_hhmm = res_data_reg.clock_hhmm;
    assign result.alarm_hhmm = res_data_reg.alarm_hhmm;
    assign result.second_odd = res_data_reg.second_odd;
    assign result.alarm_due  = res_data_reg.alarm_due;

endmodule

@@ sv/todc_update.sv @@
module todc_update
    import todc_pkg::*;
(
    input  req_t    req,
    input  state_t  cur,
    output state_t  nxt,
    output result_t res
);

    logic             up;
    logic             dn;
    logic [UnitW-1:0] hv;
    logic [UnitW-1:0] mv;
    logic [UnitW-1:0] sm;
    logic [UnitW-1:0] ss;
    logic [6:0]       sec_sum;
    logic [6:0]       min_sum;
    logic             sec_carry;
    logic [UnitW-1:0] tmp;

    // step of -2 treated as -1
    assign up = (req.step == 2'sb01);
    assign dn = req.step[1];

    assign hv = clamp_unit({1'b0, req.hour_value}, HOUR_TOP);
    assign mv = clamp_unit(req.minute_value, MINUTE_TOP);
    assign sm = clamp_unit(req.snooze_minutes, MINUTE_TOP);
    assign ss = clamp_unit(req.snooze_seconds, MINUTE_TOP);

    assign sec_sum   = {1'b0, cur.nxt_seconds} + {1'b0, ss};
    assign sec_carry = (sec_sum >= UNIT_MOD);
    assign min_sum   = {1'b0, cur.nxt_minutes} + {1'b0, sm} + {6'b0, sec_carry};

    always_comb
    begin
        nxt = cur;
        tmp = '0;
        case (cmd_t'(req.cmd))
            CMD_TICK:
            begin
                if (cur.clk_seconds >= MINUTE_TOP)
                begin
                    nxt.clk_seconds = '0;
                    if (cur.clk_minutes >= MINUTE_TOP)
                    begin
                        nxt.clk_minutes = '0;
                        tmp = nudge({1'b0, cur.clk_hours}, 1'b1, 1'b0, HOUR_TOP);
                        nxt.clk_hours = tmp[HourW-1:0];
                    end
                    else
                    begin
                        nxt.clk_minutes = cur.clk_minutes + 1'b1;
                    end
                end
                else
                begin
                    nxt.clk_seconds = cur.clk_seconds + 1'b1;
                end
            end
            CMD_CLK_HOUR:
            begin
                nxt.clk_seconds = '0;
                tmp = nudge({1'b0, cur.clk_hours}, up, dn, HOUR_TOP);
                nxt.clk_hours = tmp[HourW-1:0];
            end
            CMD_CLK_MINUTE:
            begin
                nxt.clk_seconds = '0;
                nxt.clk_minutes = nudge(cur.clk_minutes, up, dn, MINUTE_TOP);
            end
            CMD_ALM_HOUR:
            begin
                nxt.nxt_seconds = '0;
                tmp = nudge({1'b0, cur.alm_hours}, up, dn, HOUR_TOP);
                nxt.alm_hours = tmp[HourW-1:0];
                nxt.nxt_hours = tmp[HourW-1:0];
            end
            CMD_ALM_MINUTE:
            begin
                nxt.nxt_seconds = '0;
                tmp = nudge(cur.alm_minutes, up, dn, MINUTE_TOP);
                nxt.alm_minutes = tmp;
                nxt.nxt_minutes = tmp;
            end
            CMD_SET_CLOCK:
            begin
                nxt.clk_hours   = hv[HourW-1:0];
                nxt.clk_minutes = mv;
                nxt.clk_seconds = '0;
            end
            CMD_SET_ALARM:
            begin
                nxt.alm_hours   = hv[HourW-1:0];
                nxt.nxt_hours   = hv[HourW-1:0];
                nxt.alm_minutes = mv;
                nxt.nxt_minutes = mv;
                nxt.nxt_seconds = '0;
            end
            CMD_SNOOZE:
            begin
                nxt.nxt_seconds = sec_carry ? UnitW'(sec_sum - UNIT_MOD) : sec_sum[UnitW-1:0];
                if (min_sum >= UNIT_MOD)
                begin
                    nxt.nxt_minutes = UnitW'(min_sum - UNIT_MOD);
                    tmp = nudge({1'b0, cur.nxt_hours}, 1'b1, 1'b0, HOUR_TOP);
                    nxt.nxt_hours = tmp[HourW-1:0];
                end
                else
                begin
                    nxt.nxt_minutes = min_sum[UnitW-1:0];
                end
            end
            CMD_ARM:
            begin
                nxt.armed = req.arm_flag;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.clock_hhmm = to_hhmm(nxt.clk_hours, nxt.clk_minutes);
        res.alarm_hhmm = to_hhmm(nxt.alm_hours, nxt.alm_minutes);
        res.second_odd = nxt.clk_seconds[0];
        res.alarm_due  = nxt.armed
                      && (nxt.clk_seconds == nxt.nxt_seconds)
                      && (nxt.clk_minutes == nxt.nxt_minutes)
                      && (nxt.clk_hours   == nxt.nxt_hours);
    end

endmodule
